// ===== src/rri_pkg.sv =====
package rri_pkg;

	localparam int COUNT_BITS_DEF   = 32;
	localparam int SAMPLE_FRAC_BITS = 16;
	localparam int MEAN_FB          = 32;
	localparam int MOM_SHIFT        = 40;
	localparam int SAMPLE_SHIFT     = MEAN_FB - SAMPLE_FRAC_BITS;

	localparam logic [1:0] K_ADD   = 2'd0;
	localparam logic [1:0] K_DROP  = 2'd1;
	localparam logic [1:0] K_MERGE = 2'd2;
	localparam logic [1:0] K_CLEAR = 2'd3;

	typedef logic signed [127:0] wide_t;

	typedef enum logic {OP_MUL, OP_DIV} unit_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD,
		S_A1, S_A2, S_A3, S_A4,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
		S_M8, S_M9, S_M10, S_M11, S_M12, S_M13, S_M14,
		S_F1, S_F2, S_OUT
	} state_t;

	function automatic wide_t abs_w(wide_t a);
		return a[127] ? -a : a;
	endfunction

	// right shift, truncating toward zero
	function automatic wide_t shr_tz(wide_t a, int s);
		wide_t m;
		m = abs_w(a);
		m = m >> s;
		return a[127] ? -m : m;
	endfunction

	// {fault, value}
	function automatic logic [48:0] sat48(wide_t a);
		logic ok;
		ok = (&a[127:47]) | ~(|a[127:47]);
		if (ok)
			return {1'b0, a[47:0]};
		return {1'b1, a[127] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}};
	endfunction

	function automatic logic [64:0] sat64(wide_t a);
		logic ok;
		ok = (&a[127:63]) | ~(|a[127:63]);
		if (ok)
			return {1'b0, a[63:0]};
		return {1'b1, a[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}};
	endfunction

endpackage

// ===== src/running_regression_intercept_core.sv =====
// Running regression intercept over (x, y) pairs, Welford-style aggregate.
// One shared multiply/divide unit does every multiply and divide step:
//   add or drop uses it in A1 to A4, merge in M1 to M14, then F1 and F2 when the intercept is valid;
//   clear, ignored items, drops of the last pair and merges to zero skip the add and merge steps.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: arst_n clears the aggregate to zero and drops any pending result.
module running_regression_intercept_core import rri_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] val_x,
	input  logic signed [31:0] val_y,
	input  logic [31:0]        part_count,
	input  logic signed [47:0] part_mean_x,
	input  logic signed [47:0] part_mean_y,
	input  logic signed [63:0] part_sxx,
	input  logic signed [63:0] part_sxy,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] intercept,
	output logic               intercept_valid,
	output logic [31:0]        pair_count,
	output logic               fault
);

	localparam int CW = COUNT_BITS;
	localparam int RW = ((CW > 32) ? CW : 32) + 1;   // merged count, exact
	localparam int PW = (CW < 32) ? CW : 32;
	localparam logic [63:0] CMAX64 = (64'(1) << CW) - 64'(1);

	// aggregate
	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic signed [47:0] mean_x_q, mean_y_q;
	logic signed [63:0] sxx_q, sxy_q;
	logic               flt_q;

	// item registers and temporaries
	logic [1:0]         kind_q;
	logic signed [31:0] vx_q, vy_q;
	logic [31:0]        pc_q;
	logic signed [47:0] pmx_q, pmy_q, x_q, y_q, icpt_q;
	logic signed [63:0] psxx_q, psxy_q, p_q;
	logic signed [48:0] dx_q, dy_q;
	logic [63:0]        dv_q, q_q, rm_q;
	wide_t              w1_q, w2_q;

	// shared unit
	unit_op_t           uop, mode_q;
	wide_t              ua, ub, amag, bmag, umag, ures;
	logic               u_start, run_q, fin_q, neg_q, go_q, wb, is_step;
	logic [63:0]        opb_q, urem;
	logic [64:0]        hi_q, msum, dsh;
	logic [127:0]       lo_q;
	logic [65:0]        ddf;
	logic [6:0]         cnt_q;

	// misc combinational
	logic               drop, vld, full_empty, last_drop, res_over;
	logic [48:0]        sx_sat, sy_sat, s48;
	logic [64:0]        s64;
	wide_t              s48_in, s64_in, sdq, t40;
	logic [RW-1:0]      res_w;
	logic [CW-1:0]      n_w;
	state_t             load_next, nxt;
	logic [31:0]        pcnt_d;

	assign in_stall  = (state_q != S_IDLE);
	assign drop      = (kind_q == K_DROP);
	assign vld       = (count_q > CW'(1)) && !sxx_q[63] && (sxx_q != '0);
	assign sx_sat    = sat48(wide_t'(vx_q) <<< SAMPLE_SHIFT);
	assign sy_sat    = sat48(wide_t'(vy_q) <<< SAMPLE_SHIFT);
	assign full_empty = drop ? (count_q == '0) : (&count_q);
	assign last_drop = drop && (count_q == CW'(1));
	assign n_w       = drop ? count_q - CW'(1) : count_q + CW'(1);
	assign res_w     = RW'(count_q) + RW'(pc_q);
	assign res_over  = (dv_q > CMAX64);

	always_comb begin
		pcnt_d = '0;
		pcnt_d[PW-1:0] = count_q[PW-1:0];
	end

	// ---------------- shared multiply / divide unit ----------------
	// multiply: shift-add, one multiplier bit a cycle
	// divide: restoring, one quotient bit a cycle, 128 by 64
	assign amag  = abs_w(ua);
	assign bmag  = abs_w(ub);
	assign msum  = {1'b0, hi_q[63:0]} + (lo_q[0] ? {1'b0, opb_q} : 65'd0);
	assign dsh   = {hi_q[63:0], lo_q[127]};
	assign ddf   = {1'b0, dsh} - {2'b0, opb_q};
	assign umag  = (mode_q == OP_MUL) ? {hi_q[63:0], lo_q[63:0]} : lo_q;
	assign ures  = neg_q ? -umag : umag;
	assign urem  = hi_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (u_start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '0) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (u_start) begin
			mode_q <= uop;
			opb_q  <= bmag[63:0];
			neg_q  <= (uop == OP_MUL) ? (ua[127] ^ ub[127]) : ua[127];
			hi_q   <= '0;
			lo_q   <= (uop == OP_MUL) ? {64'd0, amag[63:0]} : amag;
			cnt_q  <= (uop == OP_MUL) ? 7'd63 : 7'd127;
		end else if (run_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (mode_q == OP_MUL) begin
				hi_q        <= {1'b0, msum[64:1]};
				lo_q[63:0]  <= {msum[0], lo_q[63:1]};
			end else begin
				hi_q <= ddf[65] ? dsh : ddf[64:0];
				lo_q <= {lo_q[126:0], ~ddf[65]};
			end
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		load_next = S_F1;
		case (kind_q)
			K_ADD, K_DROP: if (!full_empty && !last_drop) load_next = S_A1;
			K_MERGE:       if (res_w != '0) load_next = S_M1;
			default:       load_next = S_F1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		uop     = OP_MUL;
		ua      = '0;
		ub      = '0;
		is_step = 1'b1;
		nxt     = state_q;
		wb      = go_q && fin_q;
		case (state_q)
			S_IDLE: begin
				is_step = 1'b0;
				if (in_valid) state_d = S_LOAD;
			end
			S_LOAD: begin
				is_step = 1'b0;
				state_d = load_next;
			end
			S_A1:  begin uop = OP_DIV; ua = wide_t'(dx_q); ub = wide_t'(dv_q); nxt = S_A2; end
			S_A2:  begin uop = OP_DIV; ua = wide_t'(dy_q); ub = wide_t'(dv_q); nxt = S_A3; end
			S_A3:  begin
				ua = wide_t'(dx_q); ub = wide_t'(x_q) - wide_t'(mean_x_q); nxt = S_A4;
			end
			S_A4:  begin
				ua = wide_t'(dx_q); ub = wide_t'(y_q) - wide_t'(mean_y_q); nxt = S_F1;
			end
			S_M1:  begin ua = wide_t'(pc_q); ub = wide_t'(count_q); nxt = S_M2; end
			S_M2:  begin uop = OP_DIV; ua = w1_q; ub = wide_t'(dv_q); nxt = S_M3; end
			S_M3:  begin ua = wide_t'(dx_q); ub = wide_t'(count_q); nxt = S_M4; end
			S_M4:  begin uop = OP_DIV; ua = w1_q; ub = wide_t'(dv_q); nxt = S_M5; end
			S_M5:  begin ua = wide_t'(dy_q); ub = wide_t'(count_q); nxt = S_M6; end
			S_M6:  begin uop = OP_DIV; ua = w1_q; ub = wide_t'(dv_q); nxt = S_M7; end
			S_M7:  begin ua = wide_t'(dx_q); ub = wide_t'(dx_q); nxt = S_M8; end
			S_M8:  begin ua = wide_t'(p_q); ub = wide_t'(q_q); nxt = S_M9; end
			S_M9:  begin ua = wide_t'(p_q); ub = wide_t'(rm_q); nxt = S_M10; end
			S_M10: begin uop = OP_DIV; ua = w2_q; ub = wide_t'(dv_q); nxt = S_M11; end
			S_M11: begin ua = wide_t'(dx_q); ub = wide_t'(dy_q); nxt = S_M12; end
			S_M12: begin ua = wide_t'(p_q); ub = wide_t'(q_q); nxt = S_M13; end
			S_M13: begin ua = wide_t'(p_q); ub = wide_t'(rm_q); nxt = S_M14; end
			S_M14: begin uop = OP_DIV; ua = w2_q; ub = wide_t'(dv_q); nxt = S_F1; end
			S_F1: begin
				ua = wide_t'(sxy_q); ub = wide_t'(mean_x_q); nxt = S_F2;
				if (!vld) begin
					is_step = 1'b0;
					state_d = S_OUT;
				end
			end
			S_F2:  begin uop = OP_DIV; ua = w1_q; ub = wide_t'(sxx_q); nxt = S_OUT; end
			S_OUT: begin
				is_step = 1'b0;
				if (!out_valid || !out_stall) state_d = S_IDLE;
			end
			default: begin
				is_step = 1'b0;
				state_d = S_IDLE;
			end
		endcase
		u_start = is_step && !go_q;
		if (!is_step) wb = 1'b0;
		if (wb) state_d = nxt;
	end

	// saturating write-back paths
	always_comb begin
		sdq    = drop ? -ures : ures;
		t40    = shr_tz(ures, MOM_SHIFT);
		s48_in = shr_tz(wide_t'(mean_y_q) - ures, SAMPLE_SHIFT);
		s64_in = t40;
		case (state_q)
			S_A1:  s48_in = wide_t'(mean_x_q) + sdq;
			S_A2:  s48_in = wide_t'(mean_y_q) + sdq;
			S_M4:  s48_in = wide_t'(pmx_q) + ures;
			S_M6:  s48_in = wide_t'(pmy_q) + ures;
			default: s48_in = shr_tz(wide_t'(mean_y_q) - ures, SAMPLE_SHIFT);
		endcase
		case (state_q)
			S_A3:  s64_in = wide_t'(sxx_q) + (drop ? -t40 : t40);
			S_A4:  s64_in = wide_t'(sxy_q) + (drop ? -t40 : t40);
			S_M10: s64_in = wide_t'(sxx_q) + wide_t'(psxx_q) + w1_q + ures;
			S_M14: s64_in = wide_t'(sxy_q) + wide_t'(psxy_q) + w1_q + ures;
			default: s64_in = t40;
		endcase
	end

	assign s48 = sat48(s48_in);
	assign s64 = sat64(s64_in);

	// ---------------- aggregate and control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			go_q            <= 1'b0;
			count_q         <= '0;
			mean_x_q        <= '0;
			mean_y_q        <= '0;
			sxx_q           <= '0;
			sxy_q           <= '0;
			flt_q           <= 1'b0;
			out_valid       <= 1'b0;
			intercept       <= '0;
			intercept_valid <= 1'b0;
			pair_count      <= '0;
			fault           <= 1'b0;
		end else begin
			state_q <= state_d;
			if (u_start)
				go_q <= 1'b1;
			else if (wb)
				go_q <= 1'b0;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;

			if (state_q == S_LOAD) begin
				case (kind_q)
					K_ADD, K_DROP: begin
						flt_q <= sx_sat[48] | sy_sat[48] | full_empty;
						if (!full_empty && last_drop) begin
							count_q  <= '0;
							mean_x_q <= '0;
							mean_y_q <= '0;
							sxx_q    <= '0;
							sxy_q    <= '0;
						end
					end
					K_MERGE: begin
						flt_q <= 1'b0;
						if (res_w == '0) begin
							count_q  <= '0;
							mean_x_q <= '0;
							mean_y_q <= '0;
							sxx_q    <= '0;
							sxy_q    <= '0;
						end
					end
					default: begin
						flt_q    <= 1'b0;
						count_q  <= '0;
						mean_x_q <= '0;
						mean_y_q <= '0;
						sxx_q    <= '0;
						sxy_q    <= '0;
					end
				endcase
			end

			if (wb) begin
				case (state_q)
					S_A1, S_M4: begin
						mean_x_q <= s48[47:0];
						flt_q    <= flt_q | s48[48];
					end
					S_A2, S_M6: begin
						mean_y_q <= s48[47:0];
						flt_q    <= flt_q | s48[48];
					end
					S_A3, S_M10: begin
						sxx_q <= s64[63:0];
						flt_q <= flt_q | s64[64];
					end
					S_A4: begin
						sxy_q   <= s64[63:0];
						flt_q   <= flt_q | s64[64];
						count_q <= dv_q[CW-1:0];
					end
					S_M7, S_M11: flt_q <= flt_q | s64[64];
					S_M14: begin
						sxy_q   <= s64[63:0];
						flt_q   <= flt_q | s64[64] | res_over;
						count_q <= res_over ? {CW{1'b1}} : dv_q[CW-1:0];
					end
					S_F2: flt_q <= flt_q | s48[48];
					default: ;
				endcase
			end

			if (state_q == S_OUT && (!out_valid || !out_stall)) begin
				out_valid       <= 1'b1;
				intercept       <= icpt_q;
				intercept_valid <= vld;
				pair_count      <= pcnt_d;
				fault           <= flt_q;
			end
		end
	end

	// ---------------- item registers and temporaries ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q <= kind;
			vx_q   <= val_x;
			vy_q   <= val_y;
			pc_q   <= part_count;
			pmx_q  <= part_mean_x;
			pmy_q  <= part_mean_y;
			psxx_q <= part_sxx;
			psxy_q <= part_sxy;
		end
		if (state_q == S_LOAD) begin
			x_q <= sx_sat[47:0];
			y_q <= sy_sat[47:0];
			if (kind_q == K_MERGE) begin
				dx_q <= 49'(mean_x_q) - 49'(pmx_q);
				dy_q <= 49'(mean_y_q) - 49'(pmy_q);
				dv_q <= 64'(res_w);
			end else begin
				dx_q <= 49'($signed(sx_sat[47:0])) - 49'(mean_x_q);
				dy_q <= 49'($signed(sy_sat[47:0])) - 49'(mean_y_q);
				dv_q <= 64'(n_w);
			end
		end
		if (state_q == S_F1 && !vld)
			icpt_q <= '0;
		if (wb) begin
			case (state_q)
				S_M1, S_M3, S_M5, S_M8, S_M12, S_F1: w1_q <= ures;
				S_M9, S_M13: w2_q <= ures;
				S_M2: begin
					q_q  <= ures[63:0];
					rm_q <= urem;
				end
				S_M7, S_M11: p_q <= s64[63:0];
				S_F2: icpt_q <= s48[47:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for running_regression_intercept_core.
// A short directed table is followed by random pairs. Most random items form a sliding window:
// pairs are added, and the oldest ones are dropped again. Merges, clears and odd items are mixed in.
// Every accepted item goes through a local fixed-point model of the Welford aggregate.
// Its result, or a typed row's written one, is queued and checked against the next output.
module tb_top;
	import rri_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM       = 1630;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] x, y;
		logic [31:0]        pc;
		logic signed [47:0] pmx, pmy;
		logic signed [63:0] psxx, psxy;
	} pair_item_t;

	typedef struct {
		logic signed [47:0] icpt;
		logic               ivalid;
		logic [31:0]        cnt;
		logic               flt;
	} icpt_res_t;

	typedef struct {
		pair_item_t item;
		bit         typed;  // expected result written into the row
		icpt_res_t  res;
	} stim_row_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall;
	logic [1:0]         kind;
	logic signed [31:0] val_x, val_y;
	logic [31:0]        part_count;
	logic signed [47:0] part_mean_x, part_mean_y;
	logic signed [63:0] part_sxx, part_sxy;
	logic signed [47:0] intercept;
	logic               intercept_valid, fault;
	logic [31:0]        pair_count;

	running_regression_intercept_core u_top (.*);

	// shadow of the aggregate, all held at 128 bits signed
	wide_t agg_cnt, agg_mx, agg_my, agg_sxx, agg_sxy;
	wide_t count_max;

	icpt_res_t         icpt_q[$];
	stim_row_t         dir_rows[$];
	pair_item_t        window_q[$];
	int                send_idle_pct, recv_idle_pct;
	int                idle_cycles, n_fail, n_checked, n_items;
	int                n_valid_seen, n_fault_seen;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	// saturate to a signed width, flagging the fault
	function automatic wide_t clip(wide_t a, int bits, inout bit f);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (a > hi) begin
			f = 1'b1;
			return hi;
		end
		if (a < lo) begin
			f = 1'b1;
			return lo;
		end
		return a;
	endfunction

	// arithmetic shift rounding toward zero
	function automatic wide_t shr_zero(wide_t a, int s);
		wide_t m;
		m = (a < 0) ? -a : a;
		m = m >>> s;
		return (a < 0) ? -m : m;
	endfunction

	function automatic void agg_clear();
		agg_cnt = 0;
		agg_mx  = 0;
		agg_my  = 0;
		agg_sxx = 0;
		agg_sxy = 0;
	endfunction

	// co-moment correction for a merge: p * q + (p * rm) / total
	function automatic wide_t merge_corr(wide_t da, wide_t db, wide_t q, wide_t rm, wide_t total,
			inout bit f);
		wide_t p;
		p = clip(shr_zero(da * db, MOM_SHIFT), 64, f);
		return p * q + (p * rm) / total;
	endfunction

	// apply one item to the shadow aggregate and return the intercept that follows
	function automatic icpt_res_t intercept_step(pair_item_t it);
		icpt_res_t r;
		bit f, grow;
		wide_t x, y, n, dx, dy, sx, sy, mxn, myn, tx, ty;
		wide_t pc, total, pmx, pmy, dxm, dym, q, rm, t, quo, v;
		f = 1'b0;
		if (it.kind == K_ADD || it.kind == K_DROP) begin
			x = wide_t'(it.x) <<< SAMPLE_SHIFT;
			y = wide_t'(it.y) <<< SAMPLE_SHIFT;
			grow = (it.kind == K_ADD);
			if (grow ? (agg_cnt >= count_max) : (agg_cnt == 0)) begin
				f = 1'b1;
			end else if (!grow && agg_cnt == 1) begin
				agg_clear();
			end else begin
				n   = grow ? agg_cnt + 1 : agg_cnt - 1;
				dx  = x - agg_mx;
				dy  = y - agg_my;
				sx  = dx / n;
				sy  = dy / n;
				if (!grow) begin
					sx = -sx;
					sy = -sy;
				end
				mxn = clip(agg_mx + sx, 48, f);
				myn = clip(agg_my + sy, 48, f);
				tx  = shr_zero(dx * (x - mxn), MOM_SHIFT);
				ty  = shr_zero(dx * (y - myn), MOM_SHIFT);
				if (!grow) begin
					tx = -tx;
					ty = -ty;
				end
				agg_sxx = clip(agg_sxx + tx, 64, f);
				agg_sxy = clip(agg_sxy + ty, 64, f);
				agg_mx  = mxn;
				agg_my  = myn;
				agg_cnt = n;
			end
		end else if (it.kind == K_MERGE) begin
			pc    = wide_t'(it.pc);
			total = agg_cnt + pc;
			if (total == 0) begin
				agg_clear();
			end else begin
				pmx = wide_t'(it.pmx);
				pmy = wide_t'(it.pmy);
				dxm = agg_mx - pmx;
				dym = agg_my - pmy;
				q   = (pc * agg_cnt) / total;
				rm  = (pc * agg_cnt) % total;
				agg_mx  = clip(pmx + (dxm * agg_cnt) / total, 48, f);
				agg_my  = clip(pmy + (dym * agg_cnt) / total, 48, f);
				t       = merge_corr(dxm, dxm, q, rm, total, f);
				agg_sxx = clip(agg_sxx + wide_t'(it.psxx) + t, 64, f);
				t       = merge_corr(dxm, dym, q, rm, total, f);
				agg_sxy = clip(agg_sxy + wide_t'(it.psxy) + t, 64, f);
				if (total > count_max) begin
					total = count_max;
					f     = 1'b1;
				end
				agg_cnt = total;
			end
		end else begin
			agg_clear();
		end
		r.ivalid = (agg_cnt > 1) && (agg_sxx > 0);
		r.icpt   = '0;
		if (r.ivalid) begin
			quo    = (agg_sxy * agg_mx) / agg_sxx;
			v      = shr_zero(agg_my - quo, SAMPLE_SHIFT);
			r.icpt = clip(v, 48, f);
		end
		r.cnt = agg_cnt[31:0];
		r.flt = f;
		return r;
	endfunction

	function automatic pair_item_t mk(logic [1:0] k, logic [31:0] x, logic [31:0] y,
			logic [31:0] pc, logic [47:0] pmx, logic [47:0] pmy, logic [63:0] psxx,
			logic [63:0] psxy);
		pair_item_t it;
		it.kind = k;
		it.x    = x;
		it.y    = y;
		it.pc   = pc;
		it.pmx  = pmx;
		it.pmy  = pmy;
		it.psxx = psxx;
		it.psxy = psxy;
		return it;
	endfunction

	function automatic void add_row(pair_item_t it, bit typed, logic [47:0] icpt = '0,
			logic iv = 1'b0, logic [31:0] cnt = '0, logic flt = 1'b0);
		stim_row_t row;
		row.item       = it;
		row.typed      = typed;
		row.res.icpt   = icpt;
		row.res.ivalid = iv;
		row.res.cnt    = cnt;
		row.res.flt    = flt;
		dir_rows.push_back(row);
	endfunction

	// random magnitudes spread over every scale
	function automatic logic signed [31:0] rnd32();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic logic signed [47:0] rnd48();
		logic signed [47:0] v;
		v = 48'({$urandom, $urandom});
		return v >>> $urandom_range(0, 47);
	endfunction

	function automatic logic signed [63:0] rnd64();
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		return v >>> $urandom_range(0, 63);
	endfunction

	// mostly a sliding window of pairs, with merges, clears and noise around it
	function automatic pair_item_t rand_item();
		pair_item_t it;
		int sel;
		it  = mk(K_ADD, rnd32(), rnd32(), $urandom, rnd48(), rnd48(), rnd64(), rnd64());
		sel = $urandom_range(0, 99);
		if (sel < 60 && window_q.size() < 24) begin
			if ($urandom_range(0, 1))
				it.y = it.x + (rnd32() >>> 4);
			window_q.push_back(it);
		end else if (sel < 82) begin
			it.kind = K_DROP;
			if (window_q.size() > 0) begin
				it = window_q.pop_front();
				it.kind = K_DROP;
			end
		end else if (sel < 92) begin
			it.kind = K_MERGE;
			case ($urandom_range(0, 9))
				0: it.pc = $urandom;
				1: it.pc = '0;
				default: it.pc = $urandom_range(1, 40);
			endcase
			if ($urandom_range(0, 3) != 0) begin
				it.psxx = {1'b0, it.psxx[62:0]} >> $urandom_range(8, 40);
				it.pmx  = it.pmx >>> 8;
				it.pmy  = it.pmy >>> 8;
			end
		end else if (sel < 96) begin
			it.kind = K_CLEAR;
			window_q.delete();
		end else begin
			it.kind = $urandom_range(0, 1) ? K_DROP : K_ADD;
		end
		return it;
	endfunction

	// result side: random stall, compare each result item with the oldest expectation
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	always @(posedge clk) begin
		icpt_res_t e;
		if (out_valid && !out_stall) begin
			if (icpt_q.size() == 0) begin
				$display("%0t: result item with nothing expected: icpt %h valid %b cnt %0d flt %b",
					$time, intercept, intercept_valid, pair_count, fault);
				n_fail++;
			end else begin
				e = icpt_q.pop_front();
				n_checked++;
				if (intercept_valid)
					n_valid_seen++;
				if (fault)
					n_fault_seen++;
				if (intercept !== e.icpt) begin
					$display("%0t: intercept exp %h got %h", $time, e.icpt, intercept);
					n_fail++;
				end
				if (intercept_valid !== e.ivalid) begin
					$display("%0t: intercept_valid exp %b got %b", $time, e.ivalid,
						intercept_valid);
					n_fail++;
				end
				if (pair_count !== e.cnt) begin
					$display("%0t: pair_count exp %0d got %0d", $time, e.cnt, pair_count);
					n_fail++;
				end
				if (fault !== e.flt) begin
					$display("%0t: fault exp %b got %b", $time, e.flt, fault);
					n_fail++;
				end
			end
		end
	end

	// watchdog: any handshake on either side counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
				idle_cycles, icpt_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// present one item at the falling edge and hold it until the block takes it
	task automatic send_item(pair_item_t it, bit typed, icpt_res_t typed_res);
		icpt_res_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		kind        = it.kind;
		val_x       = it.x;
		val_y       = it.y;
		part_count  = it.pc;
		part_mean_x = it.pmx;
		part_mean_y = it.pmy;
		part_sxx    = it.psxx;
		part_sxy    = it.psxy;
		do
			@(posedge clk);
		while (in_stall);
		pred = intercept_step(it);
		icpt_q.push_back(typed ? typed_res : pred);
		n_items++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	initial begin
		icpt_res_t dummy;
		count_max     = (wide_t'(1) <<< COUNT_BITS_DEF) - 1;
		agg_clear();
		dummy         = '{default: '0};
		send_idle_pct = 25;
		recv_idle_pct = 73;
		idle_cycles   = 0;
		n_fail        = 0;
		n_checked     = 0;
		n_items       = 0;
		n_valid_seen  = 0;
		n_fault_seen  = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = K_CLEAR;
		val_x         = '0;
		val_y         = '0;
		part_count    = '0;
		part_mean_x   = '0;
		part_mean_y   = '0;
		part_sxx      = '0;
		part_sxy      = '0;

		// directed table: empty cases, sample extremes, count overflow, merge extremes
		add_row(mk(K_DROP, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0), 1, 0, 0, 0, 1);
		add_row(mk(K_MERGE, 0, 0, 0, 48'h7fffffffffff, 0, 64'h1, 0), 1, 0, 0, 0, 0);
		add_row(mk(K_ADD, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0), 1, 0, 0, 1, 0);
		add_row(mk(K_ADD, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_ADD, 0, 0, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_ADD, 32'h00010000, 32'hffff0000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_DROP, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_DROP, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_CLEAR, 32'hffffffff, 32'hffffffff, '1, '1, '1, '1, '1), 1, 0, 0, 0, 0);
		add_row(mk(K_ADD, 32'h00020000, 32'h00050000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_ADD, 32'h00040000, 32'h00090000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_ADD, 32'h00070000, 32'h000e8000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_MERGE, 0, 0, 32'hffffffff, 48'h7fffffffffff, 48'h800000000000,
			64'h7fffffffffffffff, 64'h8000000000000000), 0);
		add_row(mk(K_ADD, 32'h00010000, 32'h00010000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_DROP, 32'h00010000, 32'h00010000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_MERGE, 0, 0, 5, 48'h800000000000, 48'h7fffffffffff,
			64'h8000000000000000, 64'h7fffffffffffffff), 0);
		add_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		// dropping the only pair empties the aggregate
		add_row(mk(K_ADD, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0), 1, 0, 0, 1, 0);
		add_row(mk(K_DROP, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(mk(K_MERGE, 0, 0, 3, 48'h000200000000, 48'h000500000000,
			64'h0000000002000000, 64'h0000000003000000), 0);
		add_row(mk(K_MERGE, 0, 0, 0, 48'h123456789abc, 0, 0, 0), 0);
		add_row(mk(K_ADD, 32'hfff80000, 32'h00100000, 0, 0, 0, 0, 0), 0);
		add_row(mk(K_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		agg_clear();
		window_q.delete();

		// three idling regimes over the random part
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 25;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_item(rand_item(), 1'b0, dummy);
		end

		wait (icpt_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("Sent %0d items (window adds/drops, merges, clears); checked %0d results,",
			n_items, n_checked);
		$display("%0d with a valid intercept and %0d flagging a fault.", n_valid_seen,
			n_fault_seen);
		if (n_fail == 0 && icpt_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results missing", n_fail, icpt_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
